// ===== sv/six_step_bldc_commutator_top_macros.svh =====
// Assertion macros for the checker file sbc_checker.sv.
`ifndef SIX_STEP_BLDC_COMMUTATOR_TOP_MACROS_SVH
`define SIX_STEP_BLDC_COMMUTATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbc_pkg.sv =====
package sbc_pkg;

  // Default widths of the timer and the ADC samples
  localparam int TIME_BITS_DEF = 32;
  localparam int ADC_BITS_DEF  = 12;

  localparam int DUTY_W     = 7;
  localparam int STEP_W     = 3;
  localparam int PERIOD_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int TICKS_W    = 10;

  localparam logic [DUTY_W-1:0]   DUTY_RESET   = 7'd20;
  localparam logic [DUTY_W-1:0]   DUTY_SCALE   = 7'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;
  localparam logic [TICKS_W-1:0]  TICKS_PER_MS = 10'd1000;
  localparam logic [STEP_W-1:0]   STEP_FIRST   = 3'd0;
  localparam logic [STEP_W-1:0]   STEP_HALF    = 3'd3;
  localparam logic [STEP_W-1:0]   STEP_LAST    = 3'd5;

  typedef enum logic [1:0] {
    DRV_Z   = 2'd0,
    DRV_LOW = 2'd1,
    DRV_PWM = 2'd2
  } drive_e;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_HALL  = 2'd1,
    MODE_CMP   = 2'd2,
    MODE_DELAY = 2'd3
  } mode_e;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_PERIOD = 1'b1
  } reg_e;

  typedef struct packed {
    drive_e a;
    drive_e b;
    drive_e c;
  } pattern_t;

  typedef struct packed {
    mode_e                mode;
    logic [PERIOD_W-1:0]  period_ms;
  } cfg_t;

  typedef struct packed {
    pattern_t             drive;
    logic [DUTY_W-1:0]    duty;
    logic [STEP_W-1:0]    step;
    logic                 pulse;
    logic                 sync;
    logic                 neutral;
  } result_t;

  localparam pattern_t PATTERN_OFF = '{a: DRV_Z, b: DRV_Z, c: DRV_Z};

  // Six-step drive table
  function automatic pattern_t step_pattern(input logic [STEP_W-1:0] s);
    pattern_t p;
    case (s)
      3'd0:    p = '{a: DRV_PWM, b: DRV_LOW, c: DRV_Z};
      3'd1:    p = '{a: DRV_PWM, b: DRV_Z,   c: DRV_LOW};
      3'd2:    p = '{a: DRV_Z,   b: DRV_PWM, c: DRV_LOW};
      3'd3:    p = '{a: DRV_LOW, b: DRV_PWM, c: DRV_Z};
      3'd4:    p = '{a: DRV_LOW, b: DRV_Z,   c: DRV_PWM};
      3'd5:    p = '{a: DRV_Z,   b: DRV_LOW, c: DRV_PWM};
      default: p = PATTERN_OFF;
    endcase
    return p;
  endfunction

  function automatic logic [STEP_W-1:0] next_step(input logic [STEP_W-1:0] s);
    return (s >= STEP_LAST) ? STEP_FIRST : s + 3'd1;
  endfunction

  // Expected hall level that ends step s; lv = {c, b, a}
  function automatic logic hall_edge(input logic [STEP_W-1:0] s, input logic [2:0] lv);
    logic e;
    case (s)
      3'd0:    e = !lv[1];
      3'd1:    e = lv[2];
      3'd2:    e = !lv[0];
      3'd3:    e = lv[1];
      3'd4:    e = !lv[2];
      3'd5:    e = lv[0];
      default: e = 1'b0;
    endcase
    return e;
  endfunction

  // Expected comparator level on the floating phase; lv = {c, b, a}
  function automatic logic cmp_edge(input logic [STEP_W-1:0] s, input logic [2:0] lv);
    logic e;
    case (s)
      3'd0:    e = !lv[2];
      3'd1:    e = lv[1];
      3'd2:    e = !lv[0];
      3'd3:    e = lv[2];
      3'd4:    e = !lv[1];
      3'd5:    e = lv[0];
      default: e = 1'b0;
    endcase
    return e;
  endfunction

endpackage

// ===== sv/six_step_bldc_commutator_top.sv =====
// Six-step BLDC commutator. One input transfer is one microsecond tick; the
// block takes one tick per clock cycle unless the input is stalled and
// returns exactly one result per tick. The tick goes into an input register,
// the next commutation state is computed combinationally from it, and the
// result lands in an output register; a stall on the output holds that
// register and, once the input register is also full, stalls the input.
// There is no startup sweep: the block takes ticks from the first cycle after
// reset. Mode and open-loop period are written through the APB port (byte
// address 0 and 4); the user must write them only while no tick is in
// flight, as the block itself does not enforce it.
module six_step_bldc_commutator_top #(
  parameter int TIME_BITS = sbc_pkg::TIME_BITS_DEF,
  parameter int ADC_BITS  = sbc_pkg::ADC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            hall_a_i,
  input  logic                            hall_b_i,
  input  logic                            hall_c_i,
  input  logic                            cmp_a_i,
  input  logic                            cmp_b_i,
  input  logic                            cmp_c_i,
  input  logic [ADC_BITS-1:0]             throttle_level_i,
  input  logic [ADC_BITS-1:0]             phase_a_level_i,
  input  logic [ADC_BITS-1:0]             phase_b_level_i,
  input  logic [ADC_BITS-1:0]             phase_c_level_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      drive_a_o,
  output logic [1:0]                      drive_b_o,
  output logic [1:0]                      drive_c_o,
  output logic [sbc_pkg::DUTY_W-1:0]      duty_percent_o,
  output logic [sbc_pkg::STEP_W-1:0]      step_index_o,
  output logic                            step_pulse_o,
  output logic                            sync_out_o,
  output logic                            neutral_above_b_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sbc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sbc_pkg::*;

  cfg_t                cfg;
  result_t             res;
  result_t             out_q;

  logic                in_valid_q;
  logic [2:0]          hall_q;
  logic [2:0]          cmp_q;
  logic [ADC_BITS-1:0] throttle_q;
  logic [ADC_BITS-1:0] phase_a_q;
  logic [ADC_BITS-1:0] phase_b_q;
  logic [ADC_BITS-1:0] phase_c_q;
  logic                out_valid_q;

  logic                out_en;
  logic                fire;
  logic                in_take;

  // Handshake: output register frees up when empty or taken
  assign out_en     = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_en;
  assign in_stall_o = in_valid_q && !out_en;
  assign in_take    = in_valid_i && !in_stall_o;

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (out_en) begin
        out_valid_q <= fire;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hall_q     <= {hall_c_i, hall_b_i, hall_a_i};
      cmp_q      <= {cmp_c_i, cmp_b_i, cmp_a_i};
      throttle_q <= throttle_level_i;
      phase_a_q  <= phase_a_level_i;
      phase_b_q  <= phase_b_level_i;
      phase_c_q  <= phase_c_level_i;
    end
  end

  sbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sbc_core #(
    .TIME_BITS (TIME_BITS),
    .ADC_BITS  (ADC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cfg_i      (cfg),
    .hall_i     (hall_q),
    .cmp_i      (cmp_q),
    .throttle_i (throttle_q),
    .phase_a_i  (phase_a_q),
    .phase_b_i  (phase_b_q),
    .phase_c_i  (phase_c_q),
    .result_o   (res)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_a_o         = out_q.drive.a;
  assign drive_b_o         = out_q.drive.b;
  assign drive_c_o         = out_q.drive.c;
  assign duty_percent_o    = out_q.duty;
  assign step_index_o      = out_q.step;
  assign step_pulse_o      = out_q.pulse;
  assign sync_out_o        = out_q.sync;
  assign neutral_above_b_o = out_q.neutral;

endmodule

// ===== sv/sbc_cfg.sv =====
module sbc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sbc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output sbc_pkg::cfg_t                   cfg_o
);
  import sbc_pkg::*;

  mode_e               mode_q;
  logic [PERIOD_W-1:0] period_q;
  logic                wr_en;
  reg_e                reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[2]);

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OPEN;
      period_q <= PERIOD_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MODE:   mode_q   <= mode_e'(pwdata[1:0]);
        REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = CFG_DATA_W'(mode_q);
      REG_PERIOD: prdata = CFG_DATA_W'(period_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{mode: mode_q, period_ms: period_q};

endmodule

// ===== sv/sbc_core.sv =====
module sbc_core #(
  parameter int TIME_BITS = sbc_pkg::TIME_BITS_DEF,
  parameter int ADC_BITS  = sbc_pkg::ADC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  sbc_pkg::cfg_t        cfg_i,
  input  logic [2:0]           hall_i,
  input  logic [2:0]           cmp_i,
  input  logic [ADC_BITS-1:0]  throttle_i,
  input  logic [ADC_BITS-1:0]  phase_a_i,
  input  logic [ADC_BITS-1:0]  phase_b_i,
  input  logic [ADC_BITS-1:0]  phase_c_i,
  output sbc_pkg::result_t     result_o
);
  import sbc_pkg::*;

  localparam int PROD_W = ADC_BITS + DUTY_W;
  localparam int OPEN_W = PERIOD_W + TICKS_W;
  localparam int T6_W   = TIME_BITS + 3;
  localparam logic [ADC_BITS:0] ADC_FULL = (ADC_BITS+1)'((1 << ADC_BITS) - 1);

  // Commutation state. Time differences are kept as running counters:
  // elapsed = now - delay_start, since = now - last_commutation.
  logic [STEP_W-1:0]    step_q, step_d;
  logic                 wait_q, wait_d;
  logic [TIME_BITS-1:0] elapsed_q;
  logic [T6_W-1:0]      elapsed6_q;
  logic [TIME_BITS-1:0] since_q;
  logic [TIME_BITS-1:0] dly_q, dly_d;
  logic                 scaled_q, scaled_d;
  pattern_t             drv_q, drv_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic                 sync_q, sync_d;
  logic                 neut_q, neut_d;

  logic                 pulse;
  logic                 restart;
  logic                 commuted;
  logic                 expired;

  logic [PROD_W-1:0]    prod;
  logic [DUTY_W-1:0]    prod_hi;
  logic [ADC_BITS:0]    prod_rem;
  logic [DUTY_W-1:0]    duty_new;
  logic [ADC_BITS+1:0]  sum_ac;
  logic [ADC_BITS+1:0]  twice_b;
  logic                 neut_new;
  logic [OPEN_W-1:0]    open_ticks;

  // Duty = throttle * 100 / full scale: split the product at ADC_BITS,
  // the remainder below twice the divisor needs one correction
  assign prod     = PROD_W'(throttle_i) * PROD_W'(DUTY_SCALE);
  assign prod_hi  = prod[PROD_W-1:ADC_BITS];
  assign prod_rem = {1'b0, prod[ADC_BITS-1:0]} + (ADC_BITS+1)'(prod_hi);
  assign duty_new = prod_hi + DUTY_W'(prod_rem >= ADC_FULL);

  // floor((a+b+c)/3) > b  <=>  a + c > 2b + 2
  assign sum_ac   = (ADC_BITS+2)'(phase_a_i) + (ADC_BITS+2)'(phase_c_i);
  assign twice_b  = {1'b0, phase_b_i, 1'b0} + (ADC_BITS+2)'(2);
  assign neut_new = sum_ac > twice_b;

  assign open_ticks = OPEN_W'(cfg_i.period_ms) * OPEN_W'(TICKS_PER_MS);

  // Delayed-hall wait holds the raw period: elapsed > d/6 <=> 6*elapsed > d
  assign expired = scaled_q ? (elapsed6_q > T6_W'(dly_q)) : (elapsed_q > dly_q);

  // Per-tick step logic
  always_comb begin
    logic [STEP_W-1:0]    step_cur;
    logic [TIME_BITS-1:0] since_eff;
    logic                 proceed;
    step_d    = step_q;
    wait_d    = wait_q;
    dly_d     = dly_q;
    scaled_d  = scaled_q;
    drv_d     = drv_q;
    duty_d    = duty_q;
    sync_d    = sync_q;
    neut_d    = neut_q;
    pulse     = 1'b0;
    restart   = 1'b0;
    commuted  = 1'b0;
    step_cur  = step_q;
    since_eff = since_q;
    proceed   = 1'b1;
    case (cfg_i.mode)
      MODE_OPEN: begin
        if (!wait_q) begin
          duty_d   = duty_new;
          drv_d    = step_pattern(step_q);
          step_d   = next_step(step_q);
          restart  = 1'b1;
          dly_d    = TIME_BITS'(open_ticks);
          scaled_d = 1'b0;
          pulse    = 1'b1;
          wait_d   = 1'b1;
        end else if (expired) begin
          wait_d = 1'b0;
        end
      end
      MODE_HALL, MODE_CMP: begin
        duty_d = duty_new;
        drv_d  = step_pattern(step_q);
        if ((cfg_i.mode == MODE_HALL) ? hall_edge(step_q, hall_i)
                                      : cmp_edge(step_q, cmp_i)) begin
          step_d = next_step(step_q);
          if (cfg_i.mode == MODE_HALL) begin
            commuted = 1'b1;
            if (step_d == STEP_FIRST) begin
              sync_d = 1'b1;
              pulse  = 1'b1;
            end else if (step_d == STEP_HALF) begin
              sync_d = 1'b0;
              pulse  = 1'b1;
            end
          end
        end
      end
      MODE_DELAY: begin
        if (wait_q) begin
          if (expired) begin
            wait_d    = 1'b0;
            step_cur  = next_step(step_q);
            step_d    = step_cur;
            drv_d     = step_pattern(step_cur);
            duty_d    = duty_new;
            commuted  = 1'b1;
            since_eff = '0;
          end else begin
            proceed = 1'b0;
          end
        end
        if (proceed) begin
          neut_d = neut_new;
          if (hall_edge(step_cur, hall_i)) begin
            wait_d   = 1'b1;
            restart  = 1'b1;
            dly_d    = since_eff;
            scaled_d = 1'b1;
            if (step_cur == STEP_FIRST) begin
              sync_d = 1'b0;
            end else if (step_cur == STEP_LAST) begin
              sync_d = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // State registers, advanced once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_FIRST;
      wait_q     <= 1'b0;
      elapsed_q  <= '0;
      elapsed6_q <= '0;
      since_q    <= '0;
      dly_q      <= '0;
      scaled_q   <= 1'b0;
      drv_q      <= PATTERN_OFF;
      duty_q     <= DUTY_RESET;
      sync_q     <= 1'b0;
      neut_q     <= 1'b0;
    end else if (fire_i) begin
      step_q   <= step_d;
      wait_q   <= wait_d;
      dly_q    <= dly_d;
      scaled_q <= scaled_d;
      drv_q    <= drv_d;
      duty_q   <= duty_d;
      sync_q   <= sync_d;
      neut_q   <= neut_d;
      if (restart) begin
        elapsed_q  <= TIME_BITS'(1);
        elapsed6_q <= T6_W'(6);
      end else begin
        elapsed_q  <= elapsed_q + TIME_BITS'(1);
        // 6*elapsed follows the wrap of elapsed
        elapsed6_q <= (&elapsed_q) ? '0 : elapsed6_q + T6_W'(6);
      end
      since_q <= commuted ? TIME_BITS'(1) : since_q + TIME_BITS'(1);
    end
  end

  assign result_o = '{drive:   drv_d,
                      duty:    duty_d,
                      step:    step_d,
                      pulse:   pulse,
                      sync:    sync_d,
                      neutral: neut_d};

endmodule

// ===== sv/sbc_checker.sv =====
`include "six_step_bldc_commutator_top_macros.svh"

module sbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  drive_a_o,
  input logic [1:0]                  drive_b_o,
  input logic [1:0]                  drive_c_o,
  input logic [sbc_pkg::DUTY_W-1:0]  duty_percent_o,
  input logic [sbc_pkg::STEP_W-1:0]  step_index_o
);
  import sbc_pkg::*;

  // An empty output register never backs up the input
  `SBC_ASSERT_NOW(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")

  // Held result stays put
  `SBC_ASSERT_NXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(step_index_o) && $stable(duty_percent_o), "stalled result changed")

  // Duty and step stay in range
  `SBC_ASSERT_NOW(a_result_range, clk_i, rst_ni, out_valid_o, (duty_percent_o <= 7'd100) && (step_index_o <= STEP_LAST), "duty or step out of range")

  // Never two phases on PWM at once
  `SBC_ASSERT_NOW(a_single_pwm, clk_i, rst_ni, out_valid_o, !((drive_a_o == DRV_PWM && drive_b_o == DRV_PWM) || (drive_a_o == DRV_PWM && drive_c_o == DRV_PWM) || (drive_b_o == DRV_PWM && drive_c_o == DRV_PWM)), "two phases on PWM")

endmodule

bind six_step_bldc_commutator_top sbc_checker u_sbc_checker (.*);
